/* sv/inode_free_list_allocator_macros.svh */
// Assertion macros for the checker file of the slot allocator.
`ifndef INODE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define INODE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Implication checked at every rising edge, with a disable condition.
`define IFLA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked at the following edge.
`define IFLA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ifla_pkg.sv */
`default_nettype none

package ifla_pkg;

   localparam int SlotW    = 10;
   localparam int LinkW    = 11;
   localparam int BlockW   = 32;
   localparam int OffsetW  = 12;
   localparam int FuncW    = 2;
   localparam int StatusW  = 2;
   localparam int LinkDepth = 1024;

   localparam logic [FuncW-1:0] FUNC_FORMAT = 2'd0;
   localparam logic [FuncW-1:0] FUNC_ALLOC  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_FREE   = 2'd2;

   localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusW-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [StatusW-1:0] STATUS_RANGE     = 2'd2;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [SlotW-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [SlotW-1:0]   granted_index;
      logic [BlockW-1:0]  block_number;
      logic [OffsetW-1:0] byte_offset;
   } rsp_type;

   // Request to the slot locator.
   typedef struct packed {
      logic             start;
      logic [SlotW-1:0] slot;
   } loc_cmd_type;

   // Answer of the slot locator; done is a one-cycle pulse.
   typedef struct packed {
      logic               done;
      logic [BlockW-1:0]  block_number;
      logic [OffsetW-1:0] byte_offset;
   } loc_res_type;

endpackage

`default_nettype wire

/* sv/ifla_locate.sv */
`default_nettype none

// Maps a slot index to its disk block and byte offset. The quotient comes from
// a multiplication by the scaled reciprocal of the slots per block, and the
// remainder from a multiply-subtract in the state after.
module ifla_locate #(
   parameter int SLOTS_PER_BLOCK = 16,
   parameter int SLOT_BYTES      = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ifla_pkg::loc_cmd_type       loc_cmd,
   input  wire logic [ifla_pkg::BlockW-1:0] seg_start,
   output ifla_pkg::loc_res_type            loc_res
);
   import ifla_pkg::*;

   // With a shift of twice the index width, the rounded-up reciprocal gives the
   // exact quotient for every index and every divisor in the parameter range.
   localparam int RecipShift = 2 * SlotW;
   localparam int RecipW     = RecipShift + 1;
   localparam int ProdW      = SlotW + RecipW;
   localparam int RemW  = (SLOTS_PER_BLOCK > 1) ? $clog2(2 * SLOTS_PER_BLOCK) : 1;
   localparam logic [RecipW-1:0]  RecipM =
      RecipW'(((1 << RecipShift) + SLOTS_PER_BLOCK - 1) / SLOTS_PER_BLOCK);
   localparam logic [SlotW-1:0]   SpbW       = SlotW'(SLOTS_PER_BLOCK);
   localparam logic [OffsetW-1:0] SlotBytesW = OffsetW'(SLOT_BYTES);

   typedef enum logic [1:0] {LS_IDLE, LS_DIV, LS_REM, LS_MAP} loc_state_type;

   loc_state_type    state_ff;
   logic [SlotW-1:0] dividend_ff;
   logic [SlotW-1:0] quo_ff;
   logic [RemW-1:0]  rem_ff;
   loc_res_type      res_ff;

   logic [ProdW-1:0]   quo_prod;
   logic [SlotW-1:0]   quo_calc;
   logic [SlotW-1:0]   rem_calc;
   logic [OffsetW-1:0] rem_ext;

   assign quo_prod = ProdW'(dividend_ff) * ProdW'(RecipM);
   assign quo_calc = quo_prod[RecipShift +: SlotW];
   // The product of quotient and divisor never exceeds the index, so it fits.
   assign rem_calc = SlotW'(dividend_ff - SlotW'(quo_ff * SpbW));
   assign rem_ext  = OffsetW'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LS_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= 1'b0;
         case (state_ff)
            LS_IDLE: begin
               if (loc_cmd.start) begin
                  dividend_ff <= loc_cmd.slot;
                  state_ff    <= LS_DIV;
               end
            end
            LS_DIV: begin
               quo_ff   <= quo_calc;
               state_ff <= LS_REM;
            end
            LS_REM: begin
               rem_ff   <= RemW'(rem_calc);
               state_ff <= LS_MAP;
            end
            LS_MAP: begin
               res_ff.block_number <= BlockW'(seg_start + BlockW'(quo_ff));
               res_ff.byte_offset  <= OffsetW'(rem_ext * SlotBytesW);
               res_ff.done         <= 1'b1;
               state_ff            <= LS_IDLE;
            end
            default: begin
               state_ff <= LS_IDLE;
            end
         endcase
      end
   end

   assign loc_res = res_ff;

endmodule

`default_nettype wire

/* sv/inode_free_list_allocator.sv */
// Free-list slot allocator with a 1024-entry link store.
//
// Requests arrive on the req_ channel (valid/ready); each request transaction
// carries an operation code and, for free, a slot index. Every request yields
// exactly one response transaction on the rsp_ channel (valid/ready). The
// csr_ port writes the first disk block of the slot region; write it only
// while no request is in flight.
//
// Allocate and free that succeed pass through the three steps of the slot
// locator and the handshakes around it; rejected requests and the unused
// operation code go straight to the response. Format rewrites the link store
// one entry per cycle. One request is in flight at a time and req_ready
// stays low until its response is loaded.
//
// After reset the block runs an initialization pass over the link store and
// holds req_ready low meanwhile. If the receiver stalls, the response waits
// in the output register; the next request may still be accepted, and its
// response waits until the output register is free.
`default_nettype none

module inode_free_list_allocator #(
   parameter int NUM_BLOCKS      = 64,
   parameter int SLOTS_PER_BLOCK = 16,
   parameter int SLOT_BYTES      = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire ifla_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output ifla_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [ifla_pkg::BlockW-1:0] csr_wr_data
);
   import ifla_pkg::*;

   // Usable slots, capped at the depth of the link store.
   localparam int SlotProduct = NUM_BLOCKS * SLOTS_PER_BLOCK;
   localparam int SlotCount   = (SlotProduct > LinkDepth) ? LinkDepth : SlotProduct;
   localparam logic [LinkW-1:0] SlotCountW = LinkW'(SlotCount);
   localparam logic [SlotW-1:0] LastIdx    = SlotW'(LinkDepth - 1);

   typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_LOCATE, ST_FINISH} state_type;

   state_type        state_ff;
   logic [SlotW-1:0] sweep_ff;
   logic             fmt_reply_ff;
   logic [LinkW-1:0] head_ff;
   logic             op_alloc_ff;
   logic [BlockW-1:0] seg_start_ff;
   rsp_type          res_ff;
   rsp_type          rsp_data_ff;
   logic             rsp_valid_ff;
   loc_cmd_type      loc_cmd_ff;
   loc_res_type      loc_res;

   // Link store: one write port, one registered read port.
   logic [LinkW-1:0] link_mem [LinkDepth];
   logic [LinkW-1:0] rd_data_ff;

   logic             req_fire;
   logic             head_empty;
   logic             idx_bad;
   logic             loc_go;
   logic             rsp_load;
   rsp_type          res_init;
   logic             mem_we;
   logic [SlotW-1:0] mem_waddr;
   logic [LinkW-1:0] mem_wdata;
   logic             mem_re;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign head_empty = (head_ff >= SlotCountW);
   assign idx_bad    = ({1'b0, req_data.slot_index} >= SlotCountW);

   // Successful allocate and free requests go to the slot locator.
   assign loc_go = req_fire &&
                   ((req_data.func == FUNC_ALLOC && !head_empty) ||
                    (req_data.func == FUNC_FREE && !idx_bad));

   // The output register takes a new response when it is empty or being drained.
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Response fields known at acceptance; rejected requests carry only a status.
   always_comb begin
      res_init = '0;
      if (req_data.func == FUNC_ALLOC && head_empty) begin
         res_init.status = STATUS_EXHAUSTED;
      end else if (req_data.func == FUNC_FREE && idx_bad) begin
         res_init.status = STATUS_RANGE;
      end
   end

   // The sweep writes each entry with its successor; a successful free links
   // the freed slot to the current head in the cycle it is accepted.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = LinkW'({1'b0, sweep_ff} + 1'b1);
      mem_re    = 1'b0;
      if (state_ff == ST_SWEEP) begin
         mem_we = 1'b1;
      end else if (req_fire) begin
         if (req_data.func == FUNC_FREE && !idx_bad) begin
            mem_we    = 1'b1;
            mem_waddr = req_data.slot_index;
            mem_wdata = head_ff;
         end
         if (req_data.func == FUNC_ALLOC && !head_empty) begin
            mem_re = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
   end

   // The successor of the head is fetched at acceptance and becomes the new
   // head once the locator is done.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= link_mem[head_ff[SlotW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_ff <= BlockW'(1);
      end else if (csr_wr_en) begin
         seg_start_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         fmt_reply_ff <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         loc_cmd_ff   <= '0;
      end else begin
         loc_cmd_ff.start <= loc_go;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_SWEEP: begin
               sweep_ff <= SlotW'(sweep_ff + 1'b1);
               if (sweep_ff == LastIdx) begin
                  if (fmt_reply_ff) begin
                     res_ff   <= '0;
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  res_ff <= res_init;
                  case (req_data.func)
                     FUNC_FORMAT: begin
                        head_ff      <= '0;
                        sweep_ff     <= '0;
                        fmt_reply_ff <= 1'b1;
                        state_ff     <= ST_SWEEP;
                     end
                     FUNC_ALLOC: begin
                        if (head_empty) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           op_alloc_ff     <= 1'b1;
                           loc_cmd_ff.slot <= head_ff[SlotW-1:0];
                           state_ff        <= ST_LOCATE;
                        end
                     end
                     FUNC_FREE: begin
                        if (idx_bad) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           head_ff         <= {1'b0, req_data.slot_index};
                           op_alloc_ff     <= 1'b0;
                           loc_cmd_ff.slot <= req_data.slot_index;
                           state_ff        <= ST_LOCATE;
                        end
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_LOCATE: begin
               if (loc_res.done) begin
                  res_ff.block_number <= loc_res.block_number;
                  res_ff.byte_offset  <= loc_res.byte_offset;
                  if (op_alloc_ff) begin
                     res_ff.granted_index <= head_ff[SlotW-1:0];
                     head_ff              <= rd_data_ff;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   ifla_locate #(
      .SLOTS_PER_BLOCK(SLOTS_PER_BLOCK),
      .SLOT_BYTES     (SLOT_BYTES)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .loc_cmd  (loc_cmd_ff),
      .seg_start(seg_start_ff),
      .loc_res  (loc_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/ifla_checker.sv */
`default_nettype none

`include "inode_free_list_allocator_macros.svh"

module ifla_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire ifla_pkg::rsp_type           rsp_data,
   input wire logic                        csr_wr_en
);
   import ifla_pkg::*;

   logic rsp_fail;
   logic rsp_zero;

   assign rsp_fail = rsp_valid && (rsp_data.status != STATUS_OK);
   assign rsp_zero = (rsp_data.granted_index == '0) && (rsp_data.block_number == '0)
                     && (rsp_data.byte_offset == '0);

   // A stalled response transaction keeps its valid and its payload.
   `IFLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "response changed while stalled")

   // Rejected requests carry no slot, block or offset.
   `IFLA_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, rsp_zero,
      "failed response carries nonzero fields")

   // The initialization pass follows every reset.
   `IFLA_ASSERT_NEXT(a_init_busy, clock, 1'b0, reset, !req_ready,
      "request accepted during initialization")

   // One request in flight: acceptance closes the request channel.
   `IFLA_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready,
      !req_ready, "second request accepted back to back")

   // The region base is written only while the block is idle and empty.
   `IFLA_ASSERT_IMPLY(a_cfg_idle, clock, reset, csr_wr_en, req_ready && !rsp_valid,
      "region base written while a request is in flight")

endmodule

bind inode_free_list_allocator ifla_checker u_ifla_checker (.*);

`default_nettype wire

/* test/tb_inode_free_list_allocator.sv */
`default_nettype none

module tb_inode_free_list_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import ifla_pkg::*;

   // Geometry of the slot region. With these values the slot count is 1024, the full
   // depth of the link store. Every 10-bit index is then in range, so the range status
   // can never occur.
   localparam int NUM_BLOCKS      = 64;
   localparam int SLOTS_PER_BLOCK = 16;
   localparam int SLOT_BYTES      = 256;
   localparam int SLOT_COUNT      = (NUM_BLOCKS * SLOTS_PER_BLOCK > LinkDepth) ?
                                    LinkDepth : NUM_BLOCKS * SLOTS_PER_BLOCK;

   // The package names no code for the fourth operation, which the block answers
   // with an all-zero response.
   localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [BlockW-1:0] REGION_BASE_MIN = 32'd1;
   localparam logic [BlockW-1:0] REGION_BASE_MAX = 32'hFFFF_FFC0;

   // Every input of the block starts at a known value.
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [BlockW-1:0] csr_wr_data = '0;

   inode_free_list_allocator #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .SLOT_BYTES      (SLOT_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The testbench's own copy of the allocator state: the list head, the link of every
   // slot and the first block of the slot region.
   logic [LinkW-1:0]  list_head;
   logic [LinkW-1:0]  link_table [LinkDepth];
   logic [BlockW-1:0] region_base;

   // Responses that accepted request transactions still owe, oldest first.
   rsp_type           owed_responses [$];

   // Slots that the list has handed out and that the stimulus has not given back yet.
   // Frees drawn from here form well-formed allocate and free sequences.
   logic [SlotW-1:0]  held_slots [$];

   // Idle rates in percent of cycles, and a long receiver hold-off on request.
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_request  = 0;
   int                hold_left     = 0;

   int                mismatch_count = 0;
   int                checked_count  = 0;
   int                grant_count    = 0;
   int                exhaust_count  = 0;
   int                free_count     = 0;
   int                format_count   = 0;
   int                unused_count   = 0;
   int                longest_hold   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one request to the state copy and returns the response it must produce.
   // A granted or freed slot is located in the region: slots fill consecutive blocks
   // from the region base, SLOTS_PER_BLOCK of them per block.
   function automatic rsp_type free_list_apply(input req_type r);
      rsp_type          o;
      logic             located;
      logic [SlotW-1:0] where_slot;
      logic [31:0]      offset_full;
      int               i;
      o = '0;
      located = 1'b0;
      where_slot = '0;
      case (r.func)
         FUNC_FORMAT: begin
            for (i = 0; i < LinkDepth; i++) link_table[i] = LinkW'(i + 1);
            list_head = '0;
         end
         FUNC_ALLOC: begin
            if (list_head >= SLOT_COUNT) begin
               o.status = STATUS_EXHAUSTED;
            end else begin
               where_slot = list_head[SlotW-1:0];
               o.granted_index = where_slot;
               located = 1'b1;
               list_head = link_table[where_slot];
            end
         end
         FUNC_FREE: begin
            if (r.slot_index >= SLOT_COUNT) begin
               o.status = STATUS_RANGE;
            end else begin
               // There is no double-free check: the slot is simply pushed again.
               link_table[r.slot_index] = list_head;
               list_head = {1'b0, r.slot_index};
               where_slot = r.slot_index;
               located = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (located) begin
         o.block_number = region_base + 32'(where_slot / SLOTS_PER_BLOCK);
         offset_full = 32'(where_slot % SLOTS_PER_BLOCK) * 32'(SLOT_BYTES);
         o.byte_offset = offset_full[OffsetW-1:0];
      end
      return o;
   endfunction

   // Takes a held slot out of the pool for freeing. With nothing held, any slot will do,
   // which then amounts to freeing a slot that is already on the list.
   function automatic logic [SlotW-1:0] take_held_slot();
      logic [SlotW-1:0] s;
      int               j;
      if (held_slots.size() == 0) return SlotW'($urandom);
      j = $urandom_range(held_slots.size() - 1);
      s = held_slots[j];
      held_slots.delete(j);
      return s;
   endfunction

   task automatic note_mismatch(input string why, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t ns: %s: expected status %0d index %0d block 0x%08h offset 0x%03h,",
                  $time, why, want.status, want.granted_index, want.block_number,
                  want.byte_offset);
         $display("   got status %0d index %0d block 0x%08h offset 0x%03h",
                  got.status, got.granted_index, got.block_number, got.byte_offset);
      end
   endtask

   // Everything is sampled at the rising edge, where the inputs have been stable since the
   // falling edge. A response is checked before a request accepted at the same edge is
   // applied, because that response always belongs to an earlier request.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_type took;
      if (!reset) begin
         if (csr_wr_en) region_base = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            checked_count++;
            if (owed_responses.size() == 0) begin
               note_mismatch("response with no request waiting", '0, got);
            end else begin
               want = owed_responses.pop_front();
               if (got.status !== want.status ||
                   got.granted_index !== want.granted_index ||
                   got.block_number !== want.block_number ||
                   got.byte_offset !== want.byte_offset) begin
                  note_mismatch("response field mismatch", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            took = req_data;
            want = free_list_apply(took);
            owed_responses.push_back(want);
            case (took.func)
               FUNC_FORMAT: begin
                  format_count++;
                  held_slots.delete();
               end
               FUNC_ALLOC: begin
                  if (want.status == STATUS_OK) begin
                     grant_count++;
                     held_slots.push_back(want.granted_index);
                  end else begin
                     exhaust_count++;
                  end
               end
               FUNC_FREE: free_count++;
               default: unused_count++;
            endcase
         end
      end
   end

   // The receiver drops ready at random, or for a whole hold-off stretch when one is
   // asked for. The stretch is counted down here, cycle by cycle.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request > 0) begin
         rsp_ready <= 1'b0;
         if (hold_request > longest_hold) longest_hold = hold_request;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one request transaction and returns at the falling edge after it was taken.
   // It is entered at a falling edge. Valid is raised once and then held with a steady
   // payload until the handshake. Returning at a falling edge lets the caller pick the
   // next request after the state copy has seen this one.
   task automatic send_op(input logic [FuncW-1:0] op, input logic [SlotW-1:0] slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.func <= op;
      req_data.slot_index <= slot;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops offering, waits until every owed response has arrived, then lets the block settle.
   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Writes the region base while the block is idle.
   task automatic write_region_base(input logic [BlockW-1:0] value);
      wait_drained(4);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Directed cases: the first and last slots, block boundaries, freeing a slot that was
   // never handed out, a double free that ties a slot to itself, the unused operation code,
   // and a format in the middle of use. Ignored index fields carry extreme values.
   task automatic test_directed();
      send_op(FUNC_ALLOC, 10'h3FF);
      send_op(FUNC_ALLOC, 10'h000);
      send_op(FUNC_FREE, 10'h3FF);
      send_op(FUNC_ALLOC, 10'h155);
      send_op(FUNC_FREE, 10'h000);
      // Freeing slot 0 again makes it its own successor, so it is handed out twice.
      send_op(FUNC_FREE, 10'h000);
      send_op(FUNC_ALLOC, 10'h2AA);
      send_op(FUNC_ALLOC, 10'h3FF);
      send_op(FUNC_UNUSED, 10'h3FF);
      send_op(FUNC_UNUSED, 10'h000);
      send_op(FUNC_FORMAT, 10'h3FF);
      send_op(FUNC_ALLOC, 10'h3FF);
      send_op(FUNC_FREE, 10'h2AA);
      send_op(FUNC_FREE, 10'h155);
      send_op(FUNC_ALLOC, 10'h000);
      send_op(FUNC_ALLOC, 10'h000);
      send_op(FUNC_ALLOC, 10'h000);
      send_op(FUNC_FREE, 10'd16);
      send_op(FUNC_FREE, 10'd15);
      send_op(FUNC_ALLOC, 10'h2AA);
      send_op(FUNC_ALLOC, 10'h155);
      send_op(FUNC_FORMAT, 10'h000);
   endtask

   // Drains a freshly formatted list to the end, then keeps asking while it is empty and
   // shows that a freed slot is the only one to come back.
   task automatic test_exhaustion();
      int i;
      send_op(FUNC_FORMAT, SlotW'($urandom));
      for (i = 0; i < SLOT_COUNT; i++) send_op(FUNC_ALLOC, SlotW'($urandom));
      send_op(FUNC_ALLOC, SlotW'($urandom));
      send_op(FUNC_ALLOC, SlotW'($urandom));
      send_op(FUNC_UNUSED, SlotW'($urandom));
      send_op(FUNC_FREE, take_held_slot());
      send_op(FUNC_ALLOC, SlotW'($urandom));
      send_op(FUNC_ALLOC, SlotW'($urandom));
      send_op(FUNC_FREE, take_held_slot());
      send_op(FUNC_FREE, take_held_slot());
   endtask

   // The receiver holds off for a long stretch while requests keep coming. The block can
   // park one response and work on one more request, then it must stall its input.
   task automatic test_backpressure();
      int i;
      hold_request = 400;
      for (i = 0; i < 16; i++) begin
         if (i % 3 == 2) send_op(FUNC_FREE, take_held_slot());
         else send_op(FUNC_ALLOC, SlotW'($urandom));
      end
   endtask

   // Random traffic. Most of it consists of allocate runs and frees of held slots, so that
   // the list grows, shrinks and empties. Double frees, frees of slots already on the list,
   // the unused code and the occasional format are mixed in.
   task automatic test_random(input int count);
      int               sent;
      int               pick;
      int               run;
      int               j;
      logic [SlotW-1:0] s;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            run = $urandom_range(40, 8);
            for (j = 0; j < run; j++) send_op(FUNC_ALLOC, SlotW'($urandom));
            sent += run;
         end else if (pick < 45) begin
            send_op(FUNC_ALLOC, SlotW'($urandom));
            sent++;
         end else if (pick < 80) begin
            send_op(FUNC_FREE, take_held_slot());
            sent++;
         end else if (pick < 88) begin
            send_op(FUNC_FREE, SlotW'($urandom));
            sent++;
         end else if (pick < 92) begin
            s = take_held_slot();
            send_op(FUNC_FREE, s);
            send_op(FUNC_FREE, s);
            sent += 2;
         end else if (pick < 99) begin
            send_op(FUNC_UNUSED, SlotW'($urandom));
            sent++;
         end else begin
            send_op(FUNC_FORMAT, SlotW'($urandom));
            sent++;
         end
      end
   endtask

   // The state copy starts where the block's reset leaves it: a formatted list and a
   // region starting at block 1. After reset the block first initializes its link store on its
   // own, and the sender simply waits for ready during that pass.
   initial begin
      int i;
      for (i = 0; i < LinkDepth; i++) link_table[i] = LinkW'(i + 1);
      list_head = '0;
      region_base = REGION_BASE_MIN;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // First phase: a sender that idles now and then, a receiver that mostly stalls.
      send_idle_pct = 15;
      recv_idle_pct = 76;
      test_directed();
      write_region_base(REGION_BASE_MAX);
      test_random(280);

      // Second phase: the rates swap, and the region moves to a random base.
      send_idle_pct = 76;
      recv_idle_pct = 15;
      write_region_base($urandom_range(REGION_BASE_MAX, REGION_BASE_MIN));
      test_exhaustion();
      test_random(280);

      // Last phase: neither side idles apart from the long hold-off.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_region_base(REGION_BASE_MIN);
      test_backpressure();
      test_random(280);

      wait_drained(40);
      $display("Checked %0d responses: %0d grants, %0d exhausted, %0d frees, %0d formats,",
               checked_count, grant_count, exhaust_count, free_count, format_count);
      $display("%0d unused codes, four region bases, a %0d-cycle receiver hold-off.",
               unused_count, longest_hold);
      if (mismatch_count == 0 && owed_responses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d responses still owed",
                  mismatch_count, owed_responses.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this time.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still owed", owed_responses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
